// File: rtl/core/tnps_pkg.sv
// Shared constants and types for the three-nearest point search unit.
package tnps_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_NODES_DEF  = 1024;
    localparam int COORD_BITS_DEF = 16;

    // Squared distance format and its two reserved codes.
    localparam int DIST_W = 36;
    localparam logic [DIST_W-1:0] DIST_EMPTY = '1;
    localparam logic [DIST_W-1:0] DIST_SAT   = DIST_EMPTY - DIST_W'(1);

    // Number of held winners.
    localparam int NUM_SLOTS = 3;

    // Where a slot's contents come from after one update.
    typedef enum logic [1:0] {
        SRC_SLOT0 = 2'd0,
        SRC_SLOT1 = 2'd1,
        SRC_SLOT2 = 2'd2,
        SRC_NODE  = 2'd3
    } t_src;

    // Pipeline control handed from the top level to the slot file.
    typedef struct packed {
        logic step;   // node in the compare stage is consumed this cycle
        logic load;   // the distance stage takes a new node this cycle
        logic first;  // node in the compare stage opens a scan
    } t_rank_ctl;

endpackage

// File: rtl/core/tnps_dist.sv
// Squared Euclidean distance between two points, saturated below the empty code.
module tnps_dist #(
    parameter int COORD_BITS = tnps_pkg::COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_az,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_bz,
    output logic [tnps_pkg::DIST_W-1:0]  o_dist
);
    import tnps_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 2;
    localparam int EW = (SW > DIST_W) ? SW : DIST_W;

    logic signed [DW-1:0] dx, dy, dz;
    logic signed [PW-1:0] sqx, sqy, sqz;
    logic [SW-1:0]        sum;
    logic [EW-1:0]        sum_ext;

    // Exact differences, one extra bit so that no difference overflows.
    assign dx = $signed({i_ax[COORD_BITS-1], i_ax}) - $signed({i_bx[COORD_BITS-1], i_bx});
    assign dy = $signed({i_ay[COORD_BITS-1], i_ay}) - $signed({i_by[COORD_BITS-1], i_by});
    assign dz = $signed({i_az[COORD_BITS-1], i_az}) - $signed({i_bz[COORD_BITS-1], i_bz});

    // Squares are never negative, so they add as unsigned values.
    assign sqx = dx * dx;
    assign sqy = dy * dy;
    assign sqz = dz * dz;
    assign sum = SW'($unsigned(sqx)) + SW'($unsigned(sqy)) + SW'($unsigned(sqz));

    // Any real distance stays strictly below the empty code.
    assign sum_ext = EW'(sum);
    assign o_dist  = (sum_ext > EW'(DIST_SAT)) ? DIST_SAT : DIST_W'(sum_ext);

endmodule

// File: rtl/core/tnps_rank.sv
// Slot file of the three nearest nodes with re-scoring and the insertion cascade.
module tnps_rank #(
    parameter int MAX_NODES  = tnps_pkg::MAX_NODES_DEF,
    parameter int COORD_BITS = tnps_pkg::COORD_BITS_DEF,
    localparam int IDX_W     = $clog2(MAX_NODES)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tnps_pkg::t_rank_ctl          i_ctl,
    input  logic [IDX_W-1:0]             i_node_index,
    input  logic signed [COORD_BITS-1:0] i_node_x,
    input  logic signed [COORD_BITS-1:0] i_node_y,
    input  logic signed [COORD_BITS-1:0] i_node_z,
    input  logic [tnps_pkg::DIST_W-1:0]  i_node_dist,
    input  logic signed [COORD_BITS-1:0] i_query_x,
    input  logic signed [COORD_BITS-1:0] i_query_y,
    input  logic signed [COORD_BITS-1:0] i_query_z,
    output logic [IDX_W-1:0]             o_nearest_index,
    output logic [IDX_W-1:0]             o_second_index,
    output logic [IDX_W-1:0]             o_third_index,
    output logic                         o_nearest_valid,
    output logic                         o_second_valid,
    output logic                         o_third_valid,
    output logic [tnps_pkg::DIST_W-1:0]  o_nearest_distance_sq
);
    import tnps_pkg::*;

    localparam int NC = NUM_SLOTS + 1;

    // Held winners.
    logic [IDX_W-1:0]             r_idx  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]         r_vld;
    logic signed [COORD_BITS-1:0] r_px   [NUM_SLOTS];
    logic signed [COORD_BITS-1:0] r_py   [NUM_SLOTS];
    logic signed [COORD_BITS-1:0] r_pz   [NUM_SLOTS];
    logic [DIST_W-1:0]            r_dist [NUM_SLOTS];

    // Re-scoring candidates and the slot mapping of the update made meanwhile.
    logic [DIST_W-1:0]            r_cand [NC];
    t_src                         r_sel  [NUM_SLOTS];

    logic signed [COORD_BITS-1:0] cand_px [NC];
    logic signed [COORD_BITS-1:0] cand_py [NC];
    logic signed [COORD_BITS-1:0] cand_pz [NC];
    logic [DIST_W-1:0]            cand_d  [NC];

    logic [DIST_W-1:0]            eff    [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]         held;
    logic                         lt0, lt1, lt2;
    logic                         ins0, ins1, ins2;

    logic [IDX_W-1:0]             n_idx  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]         n_vld;
    logic signed [COORD_BITS-1:0] n_px   [NUM_SLOTS];
    logic signed [COORD_BITS-1:0] n_py   [NUM_SLOTS];
    logic signed [COORD_BITS-1:0] n_pz   [NUM_SLOTS];
    logic [DIST_W-1:0]            n_dist [NUM_SLOTS];
    t_src                         n_sel  [NUM_SLOTS];

    // Candidate positions: the slots as they stand and the node being ranked now.
    always_comb begin
        for (int j = 0; j < NUM_SLOTS; j++) begin
            cand_px[j] = r_px[j];
            cand_py[j] = r_py[j];
            cand_pz[j] = r_pz[j];
        end
        cand_px[NUM_SLOTS] = i_node_x;
        cand_py[NUM_SLOTS] = i_node_y;
        cand_pz[NUM_SLOTS] = i_node_z;
    end

    // Distances of every candidate to the query of the node entering the distance stage.
    for (genvar g = 0; g < NC; g++) begin : g_cand
        tnps_dist #(
            .COORD_BITS(COORD_BITS)
        ) u_dist (
            .i_ax  (cand_px[g]),
            .i_ay  (cand_py[g]),
            .i_az  (cand_pz[g]),
            .i_bx  (i_query_x),
            .i_by  (i_query_y),
            .i_bz  (i_query_z),
            .o_dist(cand_d[g])
        );
    end

    // Slot distances in force for this node; a scan start takes the re-scored values.
    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (i_ctl.first) begin
                eff[s] = r_vld[s] ? r_cand[r_sel[s]] : DIST_EMPTY;
            end else begin
                eff[s] = r_dist[s];
            end
            held[s] = r_vld[s] && (r_idx[s] == i_node_index);
        end
    end

    // Insertion cascade with strict compares and identity checks.
    always_comb begin
        lt0  = i_node_dist < eff[0];
        lt1  = i_node_dist < eff[1];
        lt2  = i_node_dist < eff[2];
        ins0 = lt0 && !held[0];
        ins1 = !lt0 && lt1 && !held[1] && !held[0];
        ins2 = !lt0 && !lt1 && lt2 && (held == '0);
    end

    // Next slot contents and the mapping from old slots.
    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            n_idx[s]  = r_idx[s];
            n_px[s]   = r_px[s];
            n_py[s]   = r_py[s];
            n_pz[s]   = r_pz[s];
            n_dist[s] = eff[s];
        end
        n_vld    = r_vld;
        n_sel[0] = SRC_SLOT0;
        n_sel[1] = SRC_SLOT1;
        n_sel[2] = SRC_SLOT2;

        if (ins0 || ins1) begin
            n_idx[2]  = r_idx[1];
            n_vld[2]  = r_vld[1];
            n_px[2]   = r_px[1];
            n_py[2]   = r_py[1];
            n_pz[2]   = r_pz[1];
            n_dist[2] = eff[1];
            n_sel[2]  = SRC_SLOT1;
        end
        if (ins0) begin
            n_idx[1]  = r_idx[0];
            n_vld[1]  = r_vld[0];
            n_px[1]   = r_px[0];
            n_py[1]   = r_py[0];
            n_pz[1]   = r_pz[0];
            n_dist[1] = eff[0];
            n_sel[1]  = SRC_SLOT0;
            n_idx[0]  = i_node_index;
            n_vld[0]  = 1'b1;
            n_px[0]   = i_node_x;
            n_py[0]   = i_node_y;
            n_pz[0]   = i_node_z;
            n_dist[0] = i_node_dist;
            n_sel[0]  = SRC_NODE;
        end
        if (ins1) begin
            n_idx[1]  = i_node_index;
            n_vld[1]  = 1'b1;
            n_px[1]   = i_node_x;
            n_py[1]   = i_node_y;
            n_pz[1]   = i_node_z;
            n_dist[1] = i_node_dist;
            n_sel[1]  = SRC_NODE;
        end
        if (ins2) begin
            n_idx[2]  = i_node_index;
            n_vld[2]  = 1'b1;
            n_px[2]   = i_node_x;
            n_py[2]   = i_node_y;
            n_pz[2]   = i_node_z;
            n_dist[2] = i_node_dist;
            n_sel[2]  = SRC_NODE;
        end
    end

    // Slot state advances once per consumed node.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_dist[s] <= DIST_EMPTY;
            end
        end else if (i_ctl.step) begin
            r_vld <= n_vld;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_dist[s] <= n_dist[s];
            end
        end
    end

    // Slot payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_idx[s] <= n_idx[s];
                r_px[s]  <= n_px[s];
                r_py[s]  <= n_py[s];
                r_pz[s]  <= n_pz[s];
            end
        end
    end

    // Capture candidates and the mapping of the update made in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int j = 0; j < NC; j++) begin
                r_cand[j] <= cand_d[j];
            end
            if (i_ctl.step) begin
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    r_sel[s] <= n_sel[s];
                end
            end else begin
                r_sel[0] <= SRC_SLOT0;
                r_sel[1] <= SRC_SLOT1;
                r_sel[2] <= SRC_SLOT2;
            end
        end
    end

    // Result fields as they stand after this node.
    assign o_nearest_index       = n_vld[0] ? n_idx[0] : '0;
    assign o_second_index        = n_vld[1] ? n_idx[1] : '0;
    assign o_third_index         = n_vld[2] ? n_idx[2] : '0;
    assign o_nearest_valid       = n_vld[0];
    assign o_second_valid        = n_vld[1];
    assign o_third_valid         = n_vld[2];
    assign o_nearest_distance_sq = n_vld[0] ? n_dist[0] : DIST_EMPTY;

endmodule

// File: rtl/core/three_nearest_point_search_unit.sv
// Three-nearest point search unit: streams grid nodes and reports the three
// nearest to a query point. One node is taken per clock cycle while the compare
// stage is not held, with no gap at scan boundaries. A request passes an input
// register, a stage that squares and sums the coordinate differences, and a
// compare stage that updates the three held winners; the result of a scan is
// registered when its last node is ranked and waits in an output register
// while new nodes keep flowing. On a scan start the previous winners are
// re-scored against the new query in the distance stage, alongside the node
// that is being ranked ahead of it. Input ready drops only when a finished
// result is still waiting and a second last node reaches the compare stage.
module three_nearest_point_search_unit #(
    parameter int MAX_NODES  = tnps_pkg::MAX_NODES_DEF,
    parameter int COORD_BITS = tnps_pkg::COORD_BITS_DEF,
    localparam int IDX_W     = $clog2(MAX_NODES)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [IDX_W-1:0]             i_node_index,
    input  logic signed [COORD_BITS-1:0] i_node_x,
    input  logic signed [COORD_BITS-1:0] i_node_y,
    input  logic signed [COORD_BITS-1:0] i_node_z,
    input  logic signed [COORD_BITS-1:0] i_query_x,
    input  logic signed [COORD_BITS-1:0] i_query_y,
    input  logic signed [COORD_BITS-1:0] i_query_z,
    input  logic                         i_first_node,
    input  logic                         i_last_node,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [IDX_W-1:0]             o_nearest_index,
    output logic [IDX_W-1:0]             o_second_index,
    output logic [IDX_W-1:0]             o_third_index,
    output logic                         o_nearest_valid,
    output logic                         o_second_valid,
    output logic                         o_third_valid,
    output logic [tnps_pkg::DIST_W-1:0]  o_nearest_distance_sq
);
    import tnps_pkg::*;

    // Input register stage.
    logic                         r_s1_valid;
    logic [IDX_W-1:0]             r_s1_idx;
    logic signed [COORD_BITS-1:0] r_s1_nx, r_s1_ny, r_s1_nz;
    logic signed [COORD_BITS-1:0] r_s1_qx, r_s1_qy, r_s1_qz;
    logic                         r_s1_first, r_s1_last;

    // Query held for the current scan.
    logic signed [COORD_BITS-1:0] r_qx, r_qy, r_qz;

    // Distance register stage.
    logic                         r_s2_valid;
    logic [IDX_W-1:0]             r_s2_idx;
    logic signed [COORD_BITS-1:0] r_s2_nx, r_s2_ny, r_s2_nz;
    logic [DIST_W-1:0]            r_s2_d;
    logic                         r_s2_first, r_s2_last;

    // Output register.
    logic                         r_o_valid;
    logic [IDX_W-1:0]             r_o_idx0, r_o_idx1, r_o_idx2;
    logic                         r_o_vld0, r_o_vld1, r_o_vld2;
    logic [DIST_W-1:0]            r_o_dist;

    logic                         s2_fire, s2_free, load, accept;
    logic signed [COORD_BITS-1:0] qx, qy, qz;
    logic [DIST_W-1:0]            node_d;
    t_rank_ctl                    rank_ctl;

    logic [IDX_W-1:0]             n_o_idx0, n_o_idx1, n_o_idx2;
    logic                         n_o_vld0, n_o_vld1, n_o_vld2;
    logic [DIST_W-1:0]            n_o_dist;

    // Pipeline flow: only a last node waits on the output register.
    assign s2_fire = r_s2_valid && (!r_s2_last || !r_o_valid || i_ready);
    assign s2_free = !r_s2_valid || s2_fire;
    assign load    = r_s1_valid && s2_free;
    assign o_ready = !r_s1_valid || s2_free;
    assign accept  = i_valid && o_ready;

    // A scan start brings its own query; other nodes use the held one.
    assign qx = r_s1_first ? r_s1_qx : r_qx;
    assign qy = r_s1_first ? r_s1_qy : r_qy;
    assign qz = r_s1_first ? r_s1_qz : r_qz;

    tnps_dist #(
        .COORD_BITS(COORD_BITS)
    ) u_node_dist (
        .i_ax  (r_s1_nx),
        .i_ay  (r_s1_ny),
        .i_az  (r_s1_nz),
        .i_bx  (qx),
        .i_by  (qy),
        .i_bz  (qz),
        .o_dist(node_d)
    );

    // Control for the slot file.
    always_comb begin
        rank_ctl.step  = s2_fire;
        rank_ctl.load  = load;
        rank_ctl.first = r_s2_first;
    end

    tnps_rank #(
        .MAX_NODES (MAX_NODES),
        .COORD_BITS(COORD_BITS)
    ) u_rank (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_ctl                (rank_ctl),
        .i_node_index         (r_s2_idx),
        .i_node_x             (r_s2_nx),
        .i_node_y             (r_s2_ny),
        .i_node_z             (r_s2_nz),
        .i_node_dist          (r_s2_d),
        .i_query_x            (r_s1_qx),
        .i_query_y            (r_s1_qy),
        .i_query_z            (r_s1_qz),
        .o_nearest_index      (n_o_idx0),
        .o_second_index       (n_o_idx1),
        .o_third_index        (n_o_idx2),
        .o_nearest_valid      (n_o_vld0),
        .o_second_valid       (n_o_vld1),
        .o_third_valid        (n_o_vld2),
        .o_nearest_distance_sq(n_o_dist)
    );

    // Stage valid flags, the query register and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_qx       <= '0;
            r_qy       <= '0;
            r_qz       <= '0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_free) begin
                r_s2_valid <= load;
            end
            if (load && r_s1_first) begin
                r_qx <= r_s1_qx;
                r_qy <= r_s1_qy;
                r_qz <= r_s1_qz;
            end
            if (s2_fire && r_s2_last) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_idx   <= i_node_index;
            r_s1_nx    <= i_node_x;
            r_s1_ny    <= i_node_y;
            r_s1_nz    <= i_node_z;
            r_s1_qx    <= i_query_x;
            r_s1_qy    <= i_query_y;
            r_s1_qz    <= i_query_z;
            r_s1_first <= i_first_node;
            r_s1_last  <= i_last_node;
        end
    end

    // Distance register payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s2_idx   <= r_s1_idx;
            r_s2_nx    <= r_s1_nx;
            r_s2_ny    <= r_s1_ny;
            r_s2_nz    <= r_s1_nz;
            r_s2_d     <= node_d;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
        end
    end

    // Result payload, taken when the last node of a scan is ranked.
    always_ff @(posedge i_clk) begin
        if (s2_fire && r_s2_last) begin
            r_o_idx0 <= n_o_idx0;
            r_o_idx1 <= n_o_idx1;
            r_o_idx2 <= n_o_idx2;
            r_o_vld0 <= n_o_vld0;
            r_o_vld1 <= n_o_vld1;
            r_o_vld2 <= n_o_vld2;
            r_o_dist <= n_o_dist;
        end
    end

    assign o_valid               = r_o_valid;
    assign o_nearest_index       = r_o_idx0;
    assign o_second_index        = r_o_idx1;
    assign o_third_index         = r_o_idx2;
    assign o_nearest_valid       = r_o_vld0;
    assign o_second_valid        = r_o_vld1;
    assign o_third_valid         = r_o_vld2;
    assign o_nearest_distance_sq = r_o_dist;

endmodule

// File: rtl/core/tnps_checker.sv
// Port-level checks for the three-nearest point search unit and their binding.
module tnps_checker #(
    parameter int MAX_NODES  = tnps_pkg::MAX_NODES_DEF,
    parameter int COORD_BITS = tnps_pkg::COORD_BITS_DEF,
    localparam int IDX_W     = $clog2(MAX_NODES)
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [IDX_W-1:0]             o_nearest_index,
    input logic [IDX_W-1:0]             o_second_index,
    input logic [IDX_W-1:0]             o_third_index,
    input logic                         o_nearest_valid,
    input logic                         o_second_valid,
    input logic                         o_third_valid,
    input logic [tnps_pkg::DIST_W-1:0]  o_nearest_distance_sq
);
    import tnps_pkg::*;

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result offered after reset");

    // A stalled result stays offered and holds its nearest index, nearest distance and third valid flag.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_nearest_index)
            && $stable(o_nearest_distance_sq) && $stable(o_third_valid))
        else $error("stalled result changed");

    // Slots fill from the nearest one down.
    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_third_valid || o_second_valid) |->
            o_nearest_valid && (o_second_valid || !o_third_valid))
        else $error("slot filled out of order");

    // An empty nearest slot reports the empty distance code and index zero.
    a_empty_nearest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_nearest_valid |->
            (o_nearest_distance_sq == DIST_EMPTY) && (o_nearest_index == '0))
        else $error("empty nearest slot carries data");

    // Empty lower slots report index zero.
    a_empty_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_second_valid || o_second_index == '0)
            && (o_third_valid || o_third_index == '0))
        else $error("empty slot carries an index");

endmodule

bind three_nearest_point_search_unit tnps_checker #(
    .MAX_NODES (MAX_NODES),
    .COORD_BITS(COORD_BITS)
) u_tnps_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for the three-nearest point search unit.
`timescale 1ns / 1ps

module tb;
    import tnps_pkg::*;

    localparam int IDX_W       = $clog2(MAX_NODES_DEF);
    localparam int CW          = COORD_BITS_DEF;
    localparam int NODE_TARGET = 720;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT_NS  = 5_000_000;
    localparam int MAX_REPORTS = 40;

    // One node request as the sender presents it.
    typedef struct packed {
        logic [IDX_W-1:0]     index;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] qx;
        logic signed [CW-1:0] qy;
        logic signed [CW-1:0] qz;
        logic                 first;
        logic                 last;
    } t_node_req;

    // One winner report; slot 0 is the nearest.
    typedef struct packed {
        logic [NUM_SLOTS-1:0][IDX_W-1:0] idx;
        logic [NUM_SLOTS-1:0]            ok;
        logic [DIST_W-1:0]               dsq;
    } t_winners;

    typedef enum {SPREAD_FULL, SPREAD_NEAR, SPREAD_TINY} t_spread;
    typedef enum {IDS_ANY, IDS_FEW, IDS_SEQ} t_ids;
    typedef enum {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_CHOKED} t_sink_mode;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic [IDX_W-1:0]            i_node_index = '0;
    logic signed [CW-1:0]        i_node_x = '0;
    logic signed [CW-1:0]        i_node_y = '0;
    logic signed [CW-1:0]        i_node_z = '0;
    logic signed [CW-1:0]        i_query_x = '0;
    logic signed [CW-1:0]        i_query_y = '0;
    logic signed [CW-1:0]        i_query_z = '0;
    logic                        i_first_node = 1'b0;
    logic                        i_last_node = 1'b0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic [IDX_W-1:0]            o_nearest_index;
    logic [IDX_W-1:0]            o_second_index;
    logic [IDX_W-1:0]            o_third_index;
    logic                        o_nearest_valid;
    logic                        o_second_valid;
    logic                        o_third_valid;
    logic [DIST_W-1:0]           o_nearest_distance_sq;

    three_nearest_point_search_unit u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_node_index          (i_node_index),
        .i_node_x              (i_node_x),
        .i_node_y              (i_node_y),
        .i_node_z              (i_node_z),
        .i_query_x             (i_query_x),
        .i_query_y             (i_query_y),
        .i_query_z             (i_query_z),
        .i_first_node          (i_first_node),
        .i_last_node           (i_last_node),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_nearest_index       (o_nearest_index),
        .o_second_index        (o_second_index),
        .o_third_index         (o_third_index),
        .o_nearest_valid       (o_nearest_valid),
        .o_second_valid        (o_second_valid),
        .o_third_valid         (o_third_valid),
        .o_nearest_distance_sq (o_nearest_distance_sq)
    );

    // Tracks the three held winners and the query, and checks each report.
    class winners_scoreboard;
        int                slot_idx[NUM_SLOTS];
        bit                slot_ok[NUM_SLOTS];
        int                slot_x[NUM_SLOTS];
        int                slot_y[NUM_SLOTS];
        int                slot_z[NUM_SLOTS];
        logic [DIST_W-1:0] slot_d[NUM_SLOTS];
        int                q_x;
        int                q_y;
        int                q_z;
        t_winners          reports_due[$];
        int                mismatches;
        int                reports_checked;
        int                scans_opened;

        function new();
            for (int s = 0; s < NUM_SLOTS; s++) begin
                slot_idx[s] = 0;
                slot_ok[s]  = 1'b0;
                slot_x[s]   = 0;
                slot_y[s]   = 0;
                slot_z[s]   = 0;
                slot_d[s]   = DIST_EMPTY;
            end
            q_x = 0;
            q_y = 0;
            q_z = 0;
        endfunction

        // Exact squared distance, clamped just below the empty marker.
        function logic [DIST_W-1:0] sq_dist(int ax, int ay, int az, int bx, int by, int bz);
            longint dx;
            longint dy;
            longint dz;
            longint sum;
            dx  = longint'(ax) - longint'(bx);
            dy  = longint'(ay) - longint'(by);
            dz  = longint'(az) - longint'(bz);
            sum = dx * dx + dy * dy + dz * dz;
            if (sum > longint'(DIST_SAT))
                sum = longint'(DIST_SAT);
            return sum[DIST_W-1:0];
        endfunction

        function bit holds(int s, int idx);
            return slot_ok[s] && slot_idx[s] == idx;
        endfunction

        function void shift(int dst, int src);
            slot_idx[dst] = slot_idx[src];
            slot_ok[dst]  = slot_ok[src];
            slot_x[dst]   = slot_x[src];
            slot_y[dst]   = slot_y[src];
            slot_z[dst]   = slot_z[src];
            slot_d[dst]   = slot_d[src];
        endfunction

        function void take(int s, int idx, int px, int py, int pz, logic [DIST_W-1:0] d);
            slot_idx[s] = idx;
            slot_ok[s]  = 1'b1;
            slot_x[s]   = px;
            slot_y[s]   = py;
            slot_z[s]   = pz;
            slot_d[s]   = d;
        endfunction

        // Apply one accepted node and queue a report when it closes a scan.
        function void note_node(t_node_req n);
            int                idx;
            int                px;
            int                py;
            int                pz;
            logic [DIST_W-1:0] d;
            t_winners          w;
            idx = int'(n.index);
            px  = int'($signed(n.x));
            py  = int'($signed(n.y));
            pz  = int'($signed(n.z));

            // A scan start samples the query and re-scores the stored winners.
            if (n.first) begin
                scans_opened++;
                q_x = int'($signed(n.qx));
                q_y = int'($signed(n.qy));
                q_z = int'($signed(n.qz));
                for (int s = 0; s < NUM_SLOTS; s++)
                    slot_d[s] = slot_ok[s] ?
                        sq_dist(slot_x[s], slot_y[s], slot_z[s], q_x, q_y, q_z) : DIST_EMPTY;
            end

            // Strict compares, with identity checks against the held indices.
            d = sq_dist(px, py, pz, q_x, q_y, q_z);
            if (d < slot_d[0]) begin
                if (!holds(0, idx)) begin
                    shift(2, 1);
                    shift(1, 0);
                    take(0, idx, px, py, pz, d);
                end
            end else if (d < slot_d[1]) begin
                if (!holds(1, idx) && !holds(0, idx)) begin
                    shift(2, 1);
                    take(1, idx, px, py, pz, d);
                end
            end else if (d < slot_d[2]) begin
                if (!holds(2, idx) && !holds(1, idx) && !holds(0, idx))
                    take(2, idx, px, py, pz, d);
            end

            if (n.last) begin
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    w.idx[s] = slot_ok[s] ? IDX_W'(slot_idx[s]) : '0;
                    w.ok[s]  = slot_ok[s];
                end
                w.dsq = slot_ok[0] ? slot_d[0] : DIST_EMPTY;
                reports_due = {reports_due, w};
            end
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0d, got %0d",
                             $time, field, want, got);
            end
        endfunction

        // Compare one report from the block with the oldest one queued.
        function void check_result(t_winners got);
            t_winners want;
            string    slot_name[NUM_SLOTS] = '{"nearest", "second", "third"};
            if (reports_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: report with none pending, nearest index %0d",
                             $time, got.idx[0]);
                return;
            end
            want = reports_due.pop_front();
            reports_checked++;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                compare({slot_name[s], "_index"}, 64'(want.idx[s]), 64'(got.idx[s]));
                compare({slot_name[s], "_valid"}, 64'(want.ok[s]), 64'(got.ok[s]));
            end
            compare("nearest_distance_sq", 64'(want.dsq), 64'(got.dsq));
        endfunction

        function int pending();
            return reports_due.size();
        endfunction
    endclass

    winners_scoreboard sb = new();

    int  nodes_sent = 0;
    int  burst_left = 0;
    bit  steady     = 1'b0;
    bit  src_up     = 1'b0;
    logic hold_req  = 1'b0;

    // Clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // Result side: check accepted reports, then pick the next ready value.
    always @(posedge i_clk) begin : result_sink
        t_winners   got;
        t_sink_mode mode;
        int         mode_left;
        int         hold_left;
        bit         hold_done;
        if (i_rst_n && o_valid && i_ready) begin
            got.idx[0] = o_nearest_index;
            got.idx[1] = o_second_index;
            got.idx[2] = o_third_index;
            got.ok[0]  = o_nearest_valid;
            got.ok[1]  = o_second_valid;
            got.ok[2]  = o_third_valid;
            got.dsq    = o_nearest_distance_sq;
            sb.check_result(got);
        end

        // One long hold-off so that the block backs up into its input.
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            if (mode_left <= 0) begin
                mode      = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
                SINK_OPEN:   i_ready <= 1'b1;
                SINK_COIN:   i_ready <= 1'($urandom_range(0, 1));
                SINK_MOSTLY: i_ready <= ($urandom_range(0, 9) != 0);
                default:     i_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Bursts of back-to-back requests separated by random gaps.
    task automatic pace_source();
        int gap;
        if (steady)
            return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(0, 20);
        i_valid <= 1'b0;
        src_up = 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    // Present one node request and hold it until it is taken.
    task automatic offer_node(input t_node_req n);
        i_node_index <= n.index;
        i_node_x     <= n.x;
        i_node_y     <= n.y;
        i_node_z     <= n.z;
        i_query_x    <= n.qx;
        i_query_y    <= n.qy;
        i_query_z    <= n.qz;
        i_first_node <= n.first;
        i_last_node  <= n.last;
        i_valid      <= 1'b1;
        src_up = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sb.note_node(n);
        nodes_sent++;
        pace_source();
    endtask

    function automatic t_node_req node_at(int idx, int x, int y, int z,
                                          int qx, int qy, int qz, bit first, bit last);
        t_node_req n;
        n.index = IDX_W'(idx);
        n.x     = CW'(x);
        n.y     = CW'(y);
        n.z     = CW'(z);
        n.qx    = CW'(qx);
        n.qy    = CW'(qy);
        n.qz    = CW'(qz);
        n.first = first;
        n.last  = last;
        return n;
    endfunction

    function automatic int make_coord(t_spread sp, int center);
        case (sp)
            SPREAD_NEAR: return center + int'($urandom_range(0, 128)) - 64;
            SPREAD_TINY: return int'($urandom_range(0, 6)) - 3;
            default:     return int'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int pick_index(t_ids ids, int base, int k);
        case (ids)
            IDS_FEW: return int'($urandom_range(0, 5));
            IDS_SEQ: return (base + k) % MAX_NODES_DEF;
            default: return int'($urandom_range(0, MAX_NODES_DEF - 1));
        endcase
    endfunction

    // One scan; query fields on non-opening nodes carry junk that must be ignored.
    task automatic run_scan(int len, bit with_first, bit with_last, t_spread sp, t_ids ids);
        t_node_req n;
        int        qx;
        int        qy;
        int        qz;
        int        base;
        qx   = make_coord(SPREAD_FULL, 0);
        qy   = make_coord(SPREAD_FULL, 0);
        qz   = make_coord(SPREAD_FULL, 0);
        base = $urandom_range(0, MAX_NODES_DEF - 1);
        for (int k = 0; k < len; k++) begin
            n = node_at(pick_index(ids, base, k),
                        make_coord(sp, qx), make_coord(sp, qy), make_coord(sp, qz),
                        (k == 0) ? qx : make_coord(SPREAD_FULL, 0),
                        (k == 0) ? qy : make_coord(SPREAD_FULL, 0),
                        (k == 0) ? qz : make_coord(SPREAD_FULL, 0),
                        with_first && k == 0, with_last && k == len - 1);
            offer_node(n);
        end
    endtask

    // Stimulus and end of run.
    initial begin : stimulus
        int      pick;
        int      len;
        t_spread sp;
        t_ids    ids;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Closing node before any scan start: query still at zero, two slots empty.
        offer_node(node_at(5, 256, 0, 0, 1234, -99, 7, 0, 1));
        // Opening and closing on one node, extreme coordinates on both sides.
        offer_node(node_at(7, -32768, -32768, -32768, 32767, 32767, 32767, 1, 1));
        // Far corner scan with a tie, a repeated index and the index extremes.
        offer_node(node_at(1023, 32767, 32767, 32767, -32768, -32768, -32768, 1, 0));
        offer_node(node_at(0, -32768, -32768, -32768, 0, 0, 0, 0, 0));
        offer_node(node_at(12, -32768, -32768, -32768, 0, 0, 0, 0, 0));
        offer_node(node_at(0, -32700, -32768, -32768, 0, 0, 0, 0, 0));
        offer_node(node_at(1023, -32768, -32768, -32767, 0, 0, 0, 0, 0));
        offer_node(node_at(300, 100, -100, 50, 0, 0, 0, 0, 1));
        // New query: held winners are re-scored from their stored positions.
        offer_node(node_at(301, 0, 0, 0, 21845, 10922, -1, 1, 0));
        offer_node(node_at(0, 21845, 10922, -1, 0, 0, 0, 0, 0));
        offer_node(node_at(301, 1, 1, 1, 0, 0, 0, 0, 0));
        offer_node(node_at(512, -1, -1, -1, 0, 0, 1, 0, 1));
        // Scan with no opening mark keeps the old query and distances.
        offer_node(node_at(2, 21844, 10922, -1, 0, 0, 0, 0, 0));
        offer_node(node_at(3, 21845, 10923, 0, 0, 0, 0, 0, 1));
        // Alternating bit patterns on every field.
        offer_node(node_at(682, -21846, 21845, -21846, 21845, -21846, 21845, 1, 0));
        offer_node(node_at(341, 21845, -21846, 21845, -21846, 21845, -21846, 0, 1));

        // Back-pressure: short scans offered back to back while results are held.
        hold_req <= 1'b1;
        steady = 1'b1;
        repeat (20) run_scan(2, 1, 1, SPREAD_NEAR, IDS_ANY);
        steady = 1'b0;

        // Mostly well-formed scans, with noise, unopened and unclosed scans mixed in.
        while (nodes_sent < NODE_TARGET) begin
            pick = $urandom_range(0, 19);
            sp   = t_spread'($urandom_range(0, 2));
            ids  = t_ids'($urandom_range(0, 2));
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            if (pick == 0)
                run_scan(1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         SPREAD_FULL, IDS_ANY);
            else if (pick == 1)
                run_scan(len, 1'b0, 1'b1, sp, ids);
            else if (pick == 2)
                run_scan(len, 1'b1, 1'b0, sp, ids);
            else
                run_scan(len, 1'b1, 1'b1, sp, ids);
        end
        if (src_up)
            i_valid <= 1'b0;

        // Drain, then allow a few cycles for any stray report.
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Streamed %0d node requests, %0d scan starts, %0d winner reports checked.",
                 nodes_sent, sb.scans_opened, sb.reports_checked);
        $display("Mix: coordinate extremes, ties, repeated indices, unmarked scans, %0d-cycle hold.",
                 HOLD_CYCLES);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
